FILE: rtl/core/multiplexed_seven_segment_driver_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multiplexed seven-segment driver
// Shared forms for same-cycle and next-cycle implications, both clocked and
// held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef MULTIPLEXED_SEVEN_SEGMENT_DRIVER_MACROS_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_DRIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSSD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: rtl/core/mssd_pkg.sv
// ----------------------------------------------------------------------------
// mssd_pkg
// Types, codes and segment tables shared by the seven-segment driver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mssd_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned NUM_W          = 28;
  localparam int unsigned BCD_DIGITS     = 9;
  localparam int unsigned BCD_W          = 4 * BCD_DIGITS;

  // Input function codes.
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_NUMBER = 3'd1;
  localparam logic [2:0] FUNC_DIGIT  = 3'd2;
  localparam logic [2:0] FUNC_MINUS  = 3'd3;
  localparam logic [2:0] FUNC_POINT  = 3'd4;
  localparam logic [2:0] FUNC_BLANK  = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_POLARITY = 2'd0;
  localparam logic [1:0] REG_DIGITS   = 2'd1;
  localparam logic [1:0] REG_ON_TIME  = 2'd2;
  localparam logic [1:0] REG_OFF_TIME = 2'd3;

  localparam logic [3:0]  DIGITS_RESET   = 4'd8;
  localparam logic [15:0] ON_TIME_RESET  = 16'd1000;
  localparam logic [15:0] OFF_TIME_RESET = 16'd100;

  // Anode-style codes; cathode codes are the complement.
  localparam logic [7:0] BLANK_CODE = 8'hFF;
  localparam logic [7:0] MINUS_CODE = 8'hBF;
  localparam logic [7:0] POINT_MASK = 8'h7F;
  localparam logic [7:0] POINT_BIT  = 8'h80;
  localparam logic [7:0] ENABLES_DARK_ANODE = 8'h00;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_NUMBER,
    OP_WRITE,
    OP_POINT,
    OP_NOP
  } op_t;

  // One classified command as it waits in the queue.
  typedef struct packed {
    op_t              op;
    logic [2:0]       pos;
    logic [7:0]       code;
    logic             neg;
    logic [NUM_W-1:0] mag;
  } cmd_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [BCD_W-1:0] digits;
  } bcd_stat_t;

  function automatic logic [7:0] seg_code(input logic [3:0] hex);
    logic [7:0] code;
    unique case (hex)
      4'h0: code = 8'hc0;
      4'h1: code = 8'hf9;
      4'h2: code = 8'ha4;
      4'h3: code = 8'hb0;
      4'h4: code = 8'h99;
      4'h5: code = 8'h92;
      4'h6: code = 8'h82;
      4'h7: code = 8'hf8;
      4'h8: code = 8'h80;
      4'h9: code = 8'h90;
      4'ha: code = 8'h88;
      4'hb: code = 8'h83;
      4'hc: code = 8'hc6;
      4'hd: code = 8'ha1;
      4'he: code = 8'h86;
      4'hf: code = 8'h8e;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] encode(input logic cathode, input logic [7:0] code);
    return cathode ? ~code : code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mssd_front.sv
// ----------------------------------------------------------------------------
// mssd_front
// Decodes each input item into a command and holds it in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mssd_front #(
  parameter int unsigned MAX_DIGITS = mssd_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [2:0]                        func,
  input  wire logic signed [mssd_pkg::NUM_W-1:0] number,
  input  wire logic [2:0]                        position,
  input  wire logic [3:0]                        hex_value,
  input  wire logic                              with_point,
  output logic                                   cmd_valid,
  output mssd_pkg::cmd_t                         cmd,
  input  wire logic                              cmd_pop
);

  localparam int unsigned DEPTH = mssd_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  mssd_pkg::cmd_t   cmd_in;
  mssd_pkg::cmd_t   queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pos_ok;
  logic [7:0]       hex_code;

  assign pos_ok   = 4'(position) < 4'(MAX_DIGITS);
  assign hex_code = mssd_pkg::seg_code(hex_value);

  always_comb begin
    cmd_in      = '0;
    cmd_in.op   = mssd_pkg::OP_NOP;
    cmd_in.pos  = position;
    cmd_in.neg  = number[mssd_pkg::NUM_W-1];
    // Two's complement magnitude; the most negative value comes out as 2^27.
    cmd_in.mag  = number[mssd_pkg::NUM_W-1] ? (~number + 28'd1) : number;
    unique case (func)
      mssd_pkg::FUNC_TICK: begin
        cmd_in.op = mssd_pkg::OP_TICK;
      end
      mssd_pkg::FUNC_NUMBER: begin
        cmd_in.op = mssd_pkg::OP_NUMBER;
      end
      mssd_pkg::FUNC_DIGIT: begin
        if (pos_ok) begin
          cmd_in.op   = mssd_pkg::OP_WRITE;
          cmd_in.code = with_point ? (hex_code & mssd_pkg::POINT_MASK) : hex_code;
        end
      end
      mssd_pkg::FUNC_MINUS: begin
        if (pos_ok) begin
          cmd_in.op   = mssd_pkg::OP_WRITE;
          cmd_in.code = mssd_pkg::MINUS_CODE;
        end
      end
      mssd_pkg::FUNC_POINT: begin
        if (pos_ok) begin
          cmd_in.op = mssd_pkg::OP_POINT;
        end
      end
      mssd_pkg::FUNC_BLANK: begin
        if (pos_ok) begin
          cmd_in.op   = mssd_pkg::OP_WRITE;
          cmd_in.code = mssd_pkg::BLANK_CODE;
        end
      end
      default: begin
        cmd_in.op = mssd_pkg::OP_NOP;
      end
    endcase
  end

  assign in_stall  = (count == (PTR_W+1)'(DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(cmd_pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mssd_bcd.sv
// ----------------------------------------------------------------------------
// mssd_bcd
// Shift-and-add-3 binary to BCD converter, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mssd_bcd (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [mssd_pkg::NUM_W-1:0] mag,
  input  wire logic                       ack,
  output mssd_pkg::bcd_stat_t             stat
);

  localparam int unsigned NUM_W  = mssd_pkg::NUM_W;
  localparam int unsigned BCD_W  = mssd_pkg::BCD_W;
  localparam int unsigned STEP_W = $clog2(NUM_W);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DONE
  } state_t;

  state_t            state;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  adj;
  logic [NUM_W-1:0]  bin;
  logic [STEP_W-1:0] step;

  // Every BCD digit of five or more gets three added before the shift.
  always_comb begin
    adj = bcd;
    for (int k = 0; k < mssd_pkg::BCD_DIGITS; k++) begin
      if (bcd[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (start) begin
            bin   <= mag;
            bcd   <= '0;
            step  <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          bcd  <= {adj[BCD_W-2:0], bin[NUM_W-1]};
          bin  <= {bin[NUM_W-2:0], 1'b0};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(NUM_W - 1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (ack) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign stat.busy   = (state == RUN);
  assign stat.done   = (state == DONE);
  assign stat.digits = bcd;

endmodule

`default_nettype wire

FILE: rtl/core/mssd_back.sv
// ----------------------------------------------------------------------------
// mssd_back
// Executes queued commands on the digit codes and the scan timer, holds the
// configuration registers and drives the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module mssd_back #(
  parameter int unsigned MAX_DIGITS = mssd_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 cmd_valid,
  input  wire mssd_pkg::cmd_t       cmd,
  output logic                      cmd_pop,
  output logic                      bcd_start,
  output logic                      bcd_ack,
  input  wire mssd_pkg::bcd_stat_t  bcd_stat,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                segments,
  output logic [7:0]                digit_enables
);

  localparam int unsigned LANE_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [3:0]  MAX_CNT = 4'(MAX_DIGITS);

  logic              polarity;
  logic [3:0]        digits_used;
  logic [15:0]       on_time;
  logic [15:0]       off_time;

  logic [7:0]        codes [MAX_DIGITS];
  logic [7:0]        codes_next [MAX_DIGITS];
  logic [LANE_W-1:0] scan;
  logic [LANE_W-1:0] scan_next;
  logic              dark;
  logic              dark_next;
  logic [15:0]       ticks;
  logic [15:0]       ticks_next;

  logic [3:0]        cnt;
  logic [15:0]       len;
  logic [15:0]       ticks_inc;
  logic [3:0]        ndig;
  logic              slot_free;
  logic              complete;
  logic              lit;
  logic [7:0]        onehot;
  logic [7:0]        seg_sel;
  logic [7:0]        en_sel;

  assign cfg_ready = 1'b1;
  assign cnt       = (digits_used > MAX_CNT) ? MAX_CNT : digits_used;

  // A number waits for the converter; everything else finishes once the result slot is free.
  assign slot_free = !out_valid || !out_stall;
  assign complete  = cmd_valid && slot_free &&
                     ((cmd.op != mssd_pkg::OP_NUMBER) || bcd_stat.done);
  assign cmd_pop   = complete;
  assign bcd_ack   = complete && (cmd.op == mssd_pkg::OP_NUMBER);
  assign bcd_start = cmd_valid && (cmd.op == mssd_pkg::OP_NUMBER) &&
                     !bcd_stat.busy && !bcd_stat.done;

  always_comb begin
    ndig = 4'd1;
    for (int k = 1; k < mssd_pkg::BCD_DIGITS; k++) begin
      if (bcd_stat.digits[4*k +: 4] != 4'd0) begin
        ndig = 4'(k + 1);
      end
    end
  end

  assign len       = (dark ? off_time : on_time) == 16'd0 ? 16'd1 :
                     (dark ? off_time : on_time);
  assign ticks_inc = ticks + 16'd1;

  always_comb begin
    codes_next = codes;
    scan_next  = scan;
    dark_next  = dark;
    ticks_next = ticks;
    unique case (cmd.op)
      mssd_pkg::OP_TICK: begin
        if (ticks_inc >= len) begin
          ticks_next = '0;
          if (dark) begin
            dark_next = 1'b0;
            scan_next = (4'(scan) + 4'd1 >= cnt) ? '0 : scan + LANE_W'(1);
          end else begin
            dark_next = 1'b1;
          end
        end else begin
          ticks_next = ticks_inc;
        end
      end
      mssd_pkg::OP_NUMBER: begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
          if (4'(i) < cnt) begin
            if (4'(i) >= ndig) begin
              codes_next[i] = mssd_pkg::encode(polarity, mssd_pkg::BLANK_CODE);
            end else begin
              codes_next[i] = mssd_pkg::encode(polarity,
                                mssd_pkg::seg_code(bcd_stat.digits[4*i +: 4]));
            end
            // The minus goes just above the digits when it still fits.
            if (cmd.neg && (ndig < cnt) && (4'(i) == ndig)) begin
              codes_next[i] = mssd_pkg::encode(polarity, mssd_pkg::MINUS_CODE);
            end
          end
        end
      end
      mssd_pkg::OP_WRITE: begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
          if (cmd.pos == 3'(i)) begin
            codes_next[i] = mssd_pkg::encode(polarity, cmd.code);
          end
        end
      end
      mssd_pkg::OP_POINT: begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
          if (cmd.pos == 3'(i)) begin
            codes_next[i] = polarity ? (codes[i] | mssd_pkg::POINT_BIT)
                                     : (codes[i] & mssd_pkg::POINT_MASK);
          end
        end
      end
      default: begin
        codes_next = codes;
      end
    endcase
    if (cnt == 4'd0) begin
      scan_next = '0;
    end
  end

  assign lit     = !dark_next && (4'(scan_next) < cnt);
  assign onehot  = 8'd1 << scan_next;
  assign seg_sel = codes_next[scan_next];
  assign en_sel  = lit ? mssd_pkg::encode(polarity, onehot)
                       : mssd_pkg::encode(polarity, mssd_pkg::ENABLES_DARK_ANODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      polarity    <= 1'b0;
      digits_used <= mssd_pkg::DIGITS_RESET;
      on_time     <= mssd_pkg::ON_TIME_RESET;
      off_time    <= mssd_pkg::OFF_TIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mssd_pkg::REG_POLARITY: polarity    <= cfg_data[0];
        mssd_pkg::REG_DIGITS:   digits_used <= cfg_data[3:0];
        mssd_pkg::REG_ON_TIME:  on_time     <= cfg_data;
        mssd_pkg::REG_OFF_TIME: off_time    <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        codes[i] <= mssd_pkg::BLANK_CODE;
      end
      scan      <= '0;
      dark      <= 1'b0;
      ticks     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (complete) begin
        codes         <= codes_next;
        scan          <= scan_next;
        dark          <= dark_next;
        ticks         <= ticks_next;
        segments      <= seg_sel;
        digit_enables <= en_sel;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/multiplexed_seven_segment_driver.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver
// Scans up to eight seven-segment digits from microsecond ticks and edits the
// stored digit codes from number, digit, minus, point and blank commands.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   func, number, position,
//                                               hex_value, with_point
//   result    out        out_valid / out_stall segments, digit_enables
//   config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Ticks and code edits need no converter, so they stream one per cycle while
// out_stall is low. A number write waits on the 28-step binary-to-BCD
// converter. A four-entry command queue lets input transfers go on while the
// execution stage waits on the converter or on out_stall.
// Reset is synchronous and blanks all digits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_seven_segment_driver #(
  parameter int unsigned MAX_DIGITS = mssd_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [2:0]                        func,
  input  wire logic signed [mssd_pkg::NUM_W-1:0] number,
  input  wire logic [2:0]                        position,
  input  wire logic [3:0]                        hex_value,
  input  wire logic                              with_point,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             segments,
  output logic [7:0]                             digit_enables,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [15:0]                       cfg_data
);

  mssd_pkg::cmd_t      cmd;
  mssd_pkg::bcd_stat_t bcd_stat;
  logic                cmd_valid;
  logic                cmd_pop;
  logic                bcd_start;
  logic                bcd_ack;

  mssd_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .number    (number),
    .position  (position),
    .hex_value (hex_value),
    .with_point(with_point),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  mssd_bcd u_bcd (
    .clk  (clk),
    .rst  (rst),
    .start(bcd_start),
    .mag  (cmd.mag),
    .ack  (bcd_ack),
    .stat (bcd_stat)
  );

  mssd_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .bcd_start    (bcd_start),
    .bcd_ack      (bcd_ack),
    .bcd_stat     (bcd_stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .segments     (segments),
    .digit_enables(digit_enables)
  );

endmodule

`default_nettype wire

FILE: rtl/core/mssd_checker.sv
// ----------------------------------------------------------------------------
// mssd_checker
// Port-level checks for the seven-segment driver, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multiplexed_seven_segment_driver_macros.svh"

module mssd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] segments,
  input wire logic [7:0] digit_enables
);

  // A stalled result keeps its value until it is transferred.
  `MSSD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(segments) && $stable(digit_enables))

  // At most one digit is lit, in either polarity.
  `MSSD_ASSERT_NOW(a_one_digit, clk, rst, out_valid, $onehot0(digit_enables) || $onehot0(~digit_enables))

  // The queue only fills up right after an input transfer.
  `MSSD_ASSERT_NOW(a_stall_rise, clk, rst, $rose(in_stall), $past(in_valid && !in_stall))

endmodule

bind multiplexed_seven_segment_driver mssd_checker u_checker (.*);

`default_nettype wire

FILE: dv/multiplexed_seven_segment_driver_tb.sv
// ----------------------------------------------------------------------------
// Seven-segment scan driver regression
// Runs a short table of display commands and then phased random traffic
// against a cycle-free model of the scanner and the digit store. Each phase
// reprograms polarity, digit count and slot timing while the block is idle.
// Every returned segment and enable byte is checked against the model or the
// table, under random sender bursts, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_driver_tb;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int PLAN_ROWS     = 29;

  // Function codes that the block leaves without effect.
  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  // Anode glyphs for hex digits 0 to F, digit 0 in the low byte.
  localparam logic [127:0] GLYPH_ROM = {
    8'h8e, 8'h86, 8'ha1, 8'hc6, 8'h83, 8'h88, 8'h90, 8'h80,
    8'hf8, 8'h82, 8'h92, 8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0
  };

  typedef logic signed [mssd_pkg::NUM_W-1:0] num_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct packed {
    logic [7:0] seg;
    logic [7:0] en;
  } frame_t;

  typedef struct packed {
    logic [2:0] op;
    num_t       value;
    logic [2:0] pos;
    logic [3:0] hex;
    logic       pt;
  } disp_cmd_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    logic [2:0]  op;
    num_t        value;
    logic [2:0]  pos;
    logic [3:0]  hex;
    logic        pt;
    logic        known;
    logic [7:0]  seg;
    logic [7:0]  en;
  } plan_row_t;

  typedef struct packed {
    logic        pol;
    logic [3:0]  dig;
    logic [15:0] on_t;
    logic [15:0] off_t;
  } reg_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = mssd_pkg::FUNC_TICK;
  num_t        number = '0;
  logic [2:0]  position = '0;
  logic [3:0]  hex_value = '0;
  logic        with_point = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  segments;
  logic [7:0]  digit_enables;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = mssd_pkg::REG_POLARITY;
  logic [15:0] cfg_data = '0;

  multiplexed_seven_segment_driver uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .number        (number),
    .position      (position),
    .hex_value     (hex_value),
    .with_point    (with_point),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .segments      (segments),
    .digit_enables (digit_enables),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Model of the display store, the scanner and the registers.
  logic [7:0]  shadow_codes [8];
  logic [2:0]  scan_pos;
  logic        dark_now;
  logic [15:0] phase_cnt;
  logic        cathode;
  logic [3:0]  digit_cnt;
  logic [15:0] on_len;
  logic [15:0] off_len;

  frame_t pending_frames [$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     long_hold_req = 1'b0;

  function automatic logic [7:0] glyph(input logic [3:0] h);
    return GLYPH_ROM[{h, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] polarize(input logic [7:0] code);
    return cathode ? ~code : code;
  endfunction

  function automatic int active_digits();
    return (int'(digit_cnt) > mssd_pkg::MAX_DIGITS_DEF) ? mssd_pkg::MAX_DIGITS_DEF
                                                        : int'(digit_cnt);
  endfunction

  function automatic void reset_shadow();
    foreach (shadow_codes[i]) shadow_codes[i] = mssd_pkg::BLANK_CODE;
    scan_pos  = '0;
    dark_now  = 1'b0;
    phase_cnt = '0;
    cathode   = 1'b0;
    digit_cnt = mssd_pkg::DIGITS_RESET;
    on_len    = mssd_pkg::ON_TIME_RESET;
    off_len   = mssd_pkg::OFF_TIME_RESET;
  endfunction

  function automatic void apply_register(input logic [1:0] idx, input logic [15:0] val);
    case (idx)
      mssd_pkg::REG_POLARITY: cathode   = val[0];
      mssd_pkg::REG_DIGITS:   digit_cnt = val[3:0];
      mssd_pkg::REG_ON_TIME:  on_len    = val;
      mssd_pkg::REG_OFF_TIME: off_len   = val;
      default: ;
    endcase
  endfunction

  function automatic void step_scan();
    int cnt;
    int len;
    cnt = active_digits();
    len = dark_now ? int'(off_len) : int'(on_len);
    if (len == 0) len = 1;
    phase_cnt = phase_cnt + 16'd1;
    if (int'(phase_cnt) >= len) begin
      phase_cnt = '0;
      if (dark_now) begin
        dark_now = 1'b0;
        if (int'(scan_pos) + 1 >= cnt) scan_pos = '0;
        else scan_pos = scan_pos + 3'd1;
      end else begin
        dark_now = 1'b1;
      end
    end
  endfunction

  function automatic void write_number(input num_t value);
    int v;
    int mag;
    int ndig;
    int t;
    int cnt;
    v    = value;
    mag  = (v < 0) ? -v : v;
    ndig = 0;
    t    = mag;
    do begin
      ndig++;
      t = t / 10;
    end while (t != 0);
    cnt = active_digits();
    for (int i = 0; i < cnt; i++) begin
      if (i >= ndig) shadow_codes[i] = polarize(mssd_pkg::BLANK_CODE);
      else shadow_codes[i] = polarize(glyph(4'(mag % 10)));
      mag = mag / 10;
    end
    // The minus sign only fits when a free position remains above the digits.
    if (v < 0 && ndig < cnt) shadow_codes[ndig] = polarize(mssd_pkg::MINUS_CODE);
  endfunction

  function automatic frame_t apply_command(input disp_cmd_t c);
    frame_t     f;
    int         cnt;
    logic [7:0] onehot;
    case (c.op)
      mssd_pkg::FUNC_TICK:   step_scan();
      mssd_pkg::FUNC_NUMBER: write_number(c.value);
      mssd_pkg::FUNC_DIGIT:
        shadow_codes[c.pos] = polarize(c.pt ? (glyph(c.hex) & mssd_pkg::POINT_MASK)
                                            : glyph(c.hex));
      mssd_pkg::FUNC_MINUS:  shadow_codes[c.pos] = polarize(mssd_pkg::MINUS_CODE);
      // The point is added to the stored code as it stands, in the live polarity.
      mssd_pkg::FUNC_POINT:
        shadow_codes[c.pos] = cathode ? (shadow_codes[c.pos] | mssd_pkg::POINT_BIT)
                                      : (shadow_codes[c.pos] & mssd_pkg::POINT_MASK);
      mssd_pkg::FUNC_BLANK:  shadow_codes[c.pos] = polarize(mssd_pkg::BLANK_CODE);
      default: ;
    endcase
    cnt = active_digits();
    if (cnt == 0) scan_pos = '0;
    if (!dark_now && int'(scan_pos) < cnt) begin
      onehot = 8'd1 << scan_pos;
      f.en = cathode ? ~onehot : onehot;
    end else begin
      f.en = cathode ? ~mssd_pkg::ENABLES_DARK_ANODE : mssd_pkg::ENABLES_DARK_ANODE;
    end
    f.seg = shadow_codes[scan_pos];
    return f;
  endfunction

  function automatic disp_cmd_t random_command();
    disp_cmd_t c;
    int        r;
    int        mag;
    int        lim;
    r = $urandom_range(0, 99);
    if (r < 45) c.op = mssd_pkg::FUNC_TICK;
    else if (r < 60) c.op = mssd_pkg::FUNC_NUMBER;
    else if (r < 75) c.op = mssd_pkg::FUNC_DIGIT;
    else if (r < 83) c.op = mssd_pkg::FUNC_MINUS;
    else if (r < 91) c.op = mssd_pkg::FUNC_POINT;
    else c.op = mssd_pkg::FUNC_BLANK;
    // Mostly numbers of a random digit count, so that every width shows up.
    if ($urandom_range(0, 3) == 0) begin
      mag = $urandom_range(0, 99999999);
    end else begin
      lim = 1;
      repeat ($urandom_range(1, 8)) lim = lim * 10;
      mag = $urandom_range(0, lim - 1);
    end
    c.value = num_t'($urandom_range(0, 1) ? -mag : mag);
    c.pos   = 3'($urandom_range(0, 7));
    c.hex   = 4'($urandom_range(0, 15));
    c.pt    = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Offers one command and books its expected frame once the transfer happens.
  task automatic send_command(input disp_cmd_t c, input logic known, input frame_t typed);
    frame_t f;
    in_valid   <= 1'b1;
    func       <= c.op;
    number     <= c.value;
    position   <= c.pos;
    hex_value  <= c.hex;
    with_point <= c.pt;
    do @(posedge clk); while (in_stall);
    f = apply_command(c);
    pending_frames.push_back(known ? typed : f);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    drain_results();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, val);
  endtask

  //   cfg   register      value   func           number          pos   hex
  //   point known seg     en
  plan_row_t plan [PLAN_ROWS] = '{
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_TICK,   28'sd0,         3'd0, 4'h0,
      1'b0, 1'b1, 8'hFF, 8'h01},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_NUMBER, 28'sd0,         3'd0, 4'h0,
      1'b0, 1'b1, 8'hc0, 8'h01},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_NUMBER, 28'sd99999999,  3'd0, 4'h0,
      1'b0, 1'b1, 8'h90, 8'h01},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_NUMBER, -28'sd99999999, 3'd0, 4'h0,
      1'b0, 1'b1, 8'h90, 8'h01},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_NUMBER, -28'sd5,        3'd0, 4'h0,
      1'b0, 1'b1, 8'h92, 8'h01},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_NUMBER, -28'sd1234567,  3'd0, 4'h0,
      1'b0, 1'b1, 8'hf8, 8'h01},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_DIGIT,  28'sd0,         3'd0, 4'hF,
      1'b1, 1'b1, 8'h0e, 8'h01},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_DIGIT,  28'sd0,         3'd7, 4'h0,
      1'b0, 1'b1, 8'h0e, 8'h01},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_DIGIT,  28'sd0,         3'd0, 4'hA,
      1'b0, 1'b1, 8'h88, 8'h01},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_POINT,  28'sd0,         3'd0, 4'h0,
      1'b0, 1'b1, 8'h08, 8'h01},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_MINUS,  28'sd0,         3'd0, 4'h0,
      1'b0, 1'b1, 8'hBF, 8'h01},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_BLANK,  28'sd0,         3'd0, 4'h0,
      1'b0, 1'b1, 8'hFF, 8'h01},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_POINT,  28'sd0,         3'd3, 4'h0,
      1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, FUNC_SPARE_LO,         -28'sd1,        3'd2, 4'h5,
      1'b1, 1'b0, 8'h00, 8'h00},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, FUNC_SPARE_HI,         28'sd77,        3'd7, 4'hF,
      1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_DIGIT,  28'sd0,         3'd5, 4'h8,
      1'b1, 1'b0, 8'h00, 8'h00},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_NUMBER, 28'sd12345678,  3'd0, 4'h0,
      1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b1, mssd_pkg::REG_POLARITY, 16'd1, mssd_pkg::FUNC_TICK,   28'sd0,         3'd0, 4'h0,
      1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_DIGIT,  28'sd0,         3'd0, 4'h0,
      1'b1, 1'b1, 8'hbf, 8'hfe},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_POINT,  28'sd0,         3'd1, 4'h0,
      1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b1, mssd_pkg::REG_ON_TIME,  16'd0, mssd_pkg::FUNC_TICK,   28'sd0,         3'd0, 4'h0,
      1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b1, mssd_pkg::REG_OFF_TIME, 16'd0, mssd_pkg::FUNC_TICK,   28'sd0,         3'd0, 4'h0,
      1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_TICK,   28'sd0,         3'd0, 4'h0,
      1'b0, 1'b1, 8'hbf, 8'hFF},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_TICK,   28'sd0,         3'd0, 4'h0,
      1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b1, mssd_pkg::REG_DIGITS,   16'd0, mssd_pkg::FUNC_TICK,   28'sd0,         3'd0, 4'h0,
      1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_TICK,   28'sd0,         3'd0, 4'h0,
      1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b1, mssd_pkg::REG_DIGITS,   16'd12, mssd_pkg::FUNC_TICK,  28'sd0,         3'd0, 4'h0,
      1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_TICK,   28'sd0,         3'd0, 4'h0,
      1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b0, mssd_pkg::REG_POLARITY, 16'd0, mssd_pkg::FUNC_TICK,   28'sd0,         3'd0, 4'h0,
      1'b0, 1'b0, 8'h00, 8'h00}
  };

  // Fixed phase settings; the remaining phases draw theirs at random.
  reg_set_t fixed_sets [6] = '{
    '{1'b0, 4'd8,  16'd2,     16'd1},
    '{1'b1, 4'd8,  16'd0,     16'd0},
    '{1'b1, 4'd3,  16'd1,     16'd3},
    '{1'b0, 4'd0,  16'd1,     16'd0},
    '{1'b0, 4'd15, 16'd0,     16'd2},
    '{1'b1, 4'd1,  16'd65535, 16'd65535}
  };

  initial begin
    disp_cmd_t c;
    reg_set_t  s;
    int        n;
    int        burst;
    int        gap;
    reset_shadow();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        c = '{plan[i].op, plan[i].value, plan[i].pos, plan[i].hex, plan[i].pt};
        send_command(c, plan[i].known, '{plan[i].seg, plan[i].en});
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 6) begin
        s = fixed_sets[ph];
      end else begin
        s.pol   = 1'($urandom_range(0, 1));
        s.dig   = 4'($urandom_range(0, 8));
        s.on_t  = 16'($urandom_range(0, 3));
        s.off_t = 16'($urandom_range(0, 3));
      end
      write_reg(mssd_pkg::REG_POLARITY, {15'd0, s.pol});
      write_reg(mssd_pkg::REG_DIGITS, {12'd0, s.dig});
      write_reg(mssd_pkg::REG_ON_TIME, s.on_t);
      write_reg(mssd_pkg::REG_OFF_TIME, s.off_t);
      n = 0;
      while (n < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && n < PHASE_ITEMS; b++) begin
          send_command(random_command(), 1'b0, '0);
          n++;
          // The receiver holds off for a while so that the block backs up.
          if (ph == 1 && n == 50) long_hold_req = 1'b1;
          if (ph == 3 && n == 100) drain_results();
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("multiplexed_seven_segment_driver regression: pass");
    end else begin
      $display("multiplexed_seven_segment_driver regression: fail");
    end
    $finish;
  end

  // Receiver: checks each result transfer and picks the stall for the next cycle.
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk) begin
    frame_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: segments %h enables %h", segments, digit_enables);
      end else begin
        want = pending_frames.pop_front();
        if (segments !== want.seg || digit_enables !== want.en) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: segments exp %h got %h, enables exp %h got %h",
                     want.seg, segments, want.en, digit_enables);
        end
      end
    end

    if (long_hold_req && !long_hold_done) begin
      hold_left      = LONG_HOLD;
      long_hold_done = 1'b1;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(32, 128);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (cycles % 5 < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("multiplexed_seven_segment_driver regression: fail");
      $finish;
    end
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/mssd_pkg.sv
rtl/core/mssd_front.sv
rtl/core/mssd_bcd.sv
rtl/core/mssd_back.sv
rtl/core/multiplexed_seven_segment_driver.sv
rtl/core/mssd_checker.sv
dv/multiplexed_seven_segment_driver_tb.sv
